FILE: sv/sta_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scaled tanh activation block.
// No dependencies; imported by every module of the block.
package sta_pkg;

    localparam int DATA_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int RES_W     = 32;
    localparam int OP_W      = 2;
    localparam int TANH_W    = 31;
    localparam int UMAG_W    = 31;
    localparam int FRAC_W    = 16;
    localparam int AMAG_W    = 17;
    localparam int ABMAG_W   = 31;

    localparam logic [OP_W-1:0] OP_VALUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DERIV = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_BETA = 1'd1;

    localparam logic signed [CFG_W-1:0] ALPHA_RESET = 16'sd4096;
    localparam logic signed [CFG_W-1:0] BETA_RESET  = 16'sd4096;

    localparam logic [TANH_W-1:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_in;
        logic [OP_W-1:0]          op;
    } sta_in_t;

    typedef struct packed {
        logic signed [RES_W-1:0] result_value;
        logic                    status;
    } sta_out_t;

    typedef struct packed {
        logic [TANH_W-1:0] t;
        logic              uneg;
        logic [OP_W-1:0]   op;
    } sta_tanh_t;

    typedef struct packed {
        logic [AMAG_W-1:0]  amag;
        logic               aneg;
        logic [ABMAG_W-1:0] abmag;
        logic               abneg;
    } sta_coef_t;

endpackage

FILE: sv/sta_tanh_rom.sv
`timescale 1ns / 1ps
// tanh magnitude table in Q1.30, split into even and odd banks, registered read.
// Contents are built at elaboration. Depends on sta_pkg.
module sta_tanh_rom
    import sta_pkg::*;
#(
    parameter int TABLE_SIZE = 256
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [$clog2(TABLE_SIZE/2 + 1)-1:0]    even_addr,
    input  logic [$clog2(TABLE_SIZE/2 + 1)-1:0]    odd_addr,
    output logic [TANH_W-1:0]                      even_q,
    output logic [TANH_W-1:0]                      odd_q
);

    localparam int HALF_N = TABLE_SIZE / 2 + 1;

    typedef logic [TANH_W-1:0] bank_t [HALF_N];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // q = exp(-16/N) by Taylor series, then r_k = q^k and T = (1-r)/(1+r)
    function automatic bank_t build_bank(input logic odd_sel);
        logic [63:0]       term;
        logic [63:0]       pos;
        logic [63:0]       neg;
        logic [63:0]       q;
        logic [63:0]       r;
        logic [63:0]       num;
        logic [63:0]       den;
        logic [TANH_W-1:0] tab [TABLE_SIZE + 2];
        bank_t             bank;
        term = 64'd1 << 56;
        pos  = term;
        neg  = '0;
        for (int i = 1; i < 24; i++)
        begin
            term = udiv64(term << 4, 64'(TABLE_SIZE) * 64'(i));
            if (i % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
        end
        q = ((pos - neg) + (64'd1 << 24)) >> 25;
        r = 64'd1 << 31;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (i > 0)
                r = (r * q + (64'd1 << 30)) >> 31;
            num    = ((64'd1 << 31) - r) << 30;
            den    = (64'd1 << 31) + r;
            tab[i] = TANH_W'(udiv64(num + (den >> 1), den));
        end
        tab[TABLE_SIZE]     = ONE_Q30;
        tab[TABLE_SIZE + 1] = ONE_Q30;
        for (int j = 0; j < HALF_N; j++)
            bank[j] = tab[2 * j + int'(odd_sel)];
        return bank;
    endfunction

    localparam bank_t EVEN_BANK = build_bank(1'b0);
    localparam bank_t ODD_BANK  = build_bank(1'b1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            even_q <= EVEN_BANK[even_addr];
            odd_q  <= ODD_BANK[odd_addr];
        end
    end

endmodule

FILE: sv/sta_tanh_eval.sv
`timescale 1ns / 1ps
// Five-stage front end: u = beta*x, table position, table read, interpolation, saturation.
// Depends on sta_pkg and sta_tanh_rom.
module sta_tanh_eval
    import sta_pkg::*;
#(
    parameter int TABLE_SIZE = 256
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [CFG_W-1:0] beta,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  sta_in_t                  up_data,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output sta_tanh_t                dn_data
);

    localparam int NSTG   = 5;
    localparam int HALF_N = TABLE_SIZE / 2 + 1;
    localparam int HA_W   = $clog2(HALF_N);
    localparam int P_W    = UMAG_W + $clog2(TABLE_SIZE + 1);
    localparam int K_W    = P_W - 27;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    // stage 0
    logic signed [31:0] u0;
    logic [UMAG_W-1:0]  umag0;
    logic [UMAG_W-1:0]  umag_reg;
    logic               uneg0_reg;
    logic [OP_W-1:0]    op0_reg;

    // stage 1
    logic [P_W-1:0]     p1;
    logic [K_W-1:0]     kraw1;
    logic [K_W-1:0]     kc1;
    logic [K_W-1:0]     kp1;
    logic               sat1;
    logic [HA_W-1:0]    ea_reg;
    logic [HA_W-1:0]    oa_reg;
    logic               k0_1_reg;
    logic [FRAC_W-1:0]  frac1_reg;
    logic               sat1_reg;
    logic               uneg1_reg;
    logic [OP_W-1:0]    op1_reg;

    // stage 2
    logic [TANH_W-1:0]  even_q;
    logic [TANH_W-1:0]  odd_q;
    logic               k0_2_reg;
    logic [FRAC_W-1:0]  frac2_reg;
    logic               sat2_reg;
    logic               uneg2_reg;
    logic [OP_W-1:0]    op2_reg;

    // stage 3
    logic [TANH_W-1:0]  lo3;
    logic [TANH_W-1:0]  hi3;
    logic [TANH_W-1:0]  diff3;
    logic [46:0]        prod3;
    logic [TANH_W-1:0]  lo3_reg;
    logic [TANH_W-1:0]  ip3_reg;
    logic               sat3_reg;
    logic               uneg3_reg;
    logic [OP_W-1:0]    op3_reg;

    // stage 4
    logic [TANH_W-1:0]  t4;
    sta_tanh_t          dn_data_reg;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || dn_ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NSTG-1];
    assign dn_data  = dn_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= up_valid;
            for (int i = 1; i < NSTG; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_comb
    begin
        u0    = 32'(beta) * 32'(up_data.sample_in);
        umag0 = u0[31] ? UMAG_W'(-u0) : UMAG_W'(u0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            umag_reg  <= umag0;
            uneg0_reg <= u0[31];
            op0_reg   <= up_data.op;
        end
    end

    always_comb
    begin
        p1    = P_W'(umag_reg) * P_W'(TABLE_SIZE);
        kraw1 = p1[P_W-1:27];
        sat1  = kraw1 >= K_W'(TABLE_SIZE);
        kc1   = sat1 ? '0 : kraw1;
        kp1   = kc1 + K_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ea_reg    <= HA_W'(kp1 >> 1);
            oa_reg    <= HA_W'(kc1 >> 1);
            k0_1_reg  <= kc1[0];
            frac1_reg <= p1[26:11];
            sat1_reg  <= sat1;
            uneg1_reg <= uneg0_reg;
            op1_reg   <= op0_reg;
        end
    end

    sta_tanh_rom #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_rom (
        .clk       (clk),
        .en        (en[2]),
        .even_addr (ea_reg),
        .odd_addr  (oa_reg),
        .even_q    (even_q),
        .odd_q     (odd_q)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            k0_2_reg  <= k0_1_reg;
            frac2_reg <= frac1_reg;
            sat2_reg  <= sat1_reg;
            uneg2_reg <= uneg1_reg;
            op2_reg   <= op1_reg;
        end
    end

    always_comb
    begin
        lo3   = k0_2_reg ? odd_q : even_q;
        hi3   = k0_2_reg ? even_q : odd_q;
        diff3 = hi3 - lo3;
        prod3 = 47'(diff3) * 47'(frac2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            lo3_reg   <= lo3;
            ip3_reg   <= prod3[46:16];
            sat3_reg  <= sat2_reg;
            uneg3_reg <= uneg2_reg;
            op3_reg   <= op2_reg;
        end
    end

    assign t4 = sat3_reg ? ONE_Q30 : lo3_reg + ip3_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            dn_data_reg.t    <= t4;
            dn_data_reg.uneg <= uneg3_reg;
            dn_data_reg.op   <= op3_reg;
        end
    end

endmodule

FILE: sv/sta_scale.sv
`timescale 1ns / 1ps
// Four-stage back end: alpha*t or 1 - t^2 times alpha*beta, rounding, sign, clamp.
// Depends on sta_pkg.
module sta_scale
    import sta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sta_coef_t coef,
    input  logic      up_valid,
    output logic      up_ready,
    input  sta_tanh_t up_data,
    output logic      dn_valid,
    input  logic      dn_ready,
    output sta_out_t  dn_data
);

    localparam int NSTG = 4;
    localparam int MAG_W = 36;
    localparam logic [61:0] RND25 = 62'd1 << 25;
    localparam logic [61:0] RND29 = 62'd1 << 29;
    localparam logic [61:0] RND37 = 62'd1 << 37;
    localparam logic [MAG_W-1:0] NEG_LIM = 36'h0_8000_0000;
    localparam logic [MAG_W-1:0] POS_LIM = 36'h0_7FFF_FFFF;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;

    logic [TANH_W-1:0] mult_b0;
    logic [61:0]       m_reg;
    logic [OP_W-1:0]   op_a_reg;
    logic              neg_a_reg;

    logic [61:0]       sum25;
    logic [61:0]       sum29;
    logic [31:0]       t2;
    logic [TANH_W-1:0] d1;
    logic [MAG_W-1:0]  mag0_b_reg;
    logic [TANH_W-1:0] d_b_reg;
    logic [OP_W-1:0]   op_b_reg;
    logic              neg_b_reg;

    logic [61:0]       p_c_reg;
    logic [MAG_W-1:0]  mag0_c_reg;
    logic [OP_W-1:0]   op_c_reg;
    logic              neg_c_reg;

    logic [61:0]       sum37;
    logic [MAG_W-1:0]  mag3;
    logic [MAG_W-1:0]  clamp3;
    logic              neg3;
    sta_out_t          res3;
    sta_out_t          dn_data_reg;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || dn_ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NSTG-1];
    assign dn_data  = dn_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= up_valid;
            for (int i = 1; i < NSTG; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // one shared multiplier: t*t for the derivative, |alpha|*t for the value
    assign mult_b0 = (up_data.op == OP_DERIV) ? up_data.t : TANH_W'(coef.amag);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m_reg     <= 62'(up_data.t) * 62'(mult_b0);
            op_a_reg  <= up_data.op;
            neg_a_reg <= coef.aneg ^ up_data.uneg;
        end
    end

    always_comb
    begin
        sum25 = m_reg + RND25;
        sum29 = m_reg + RND29;
        t2    = sum29[61:30];
        d1    = (t2 >= 32'(ONE_Q30)) ? '0 : TANH_W'(32'(ONE_Q30) - t2);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mag0_b_reg <= sum25[61:26];
            d_b_reg    <= d1;
            op_b_reg   <= op_a_reg;
            neg_b_reg  <= neg_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p_c_reg    <= 62'(coef.abmag) * 62'(d_b_reg);
            mag0_c_reg <= mag0_b_reg;
            op_c_reg   <= op_b_reg;
            neg_c_reg  <= neg_b_reg;
        end
    end

    always_comb
    begin
        sum37 = p_c_reg + RND37;
        mag3  = (op_c_reg == OP_VALUE) ? mag0_c_reg : MAG_W'(sum37[61:38]);
        neg3  = ((op_c_reg == OP_VALUE) ? neg_c_reg : coef.abneg) && (mag3 != '0);
        if (neg3)
        begin
            clamp3            = (mag3 > NEG_LIM) ? NEG_LIM : mag3;
            res3.result_value = RES_W'(-clamp3);
        end
        else
        begin
            clamp3            = (mag3 > POS_LIM) ? POS_LIM : mag3;
            res3.result_value = RES_W'(clamp3);
        end
        res3.status = 1'b0;
        if (op_c_reg > OP_DERIV)
        begin
            res3.result_value = '0;
            res3.status       = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            dn_data_reg <= res3;
    end

endmodule

FILE: sv/scaled_tanh_activation.sv
`timescale 1ns / 1ps
// Top level of the scaled tanh activation: configuration registers and the
// nine-stage pipeline. Depends on sta_pkg, sta_tanh_eval and sta_scale.
//
//   channel  | direction | handshake                     | payload
//   ---------+-----------+-------------------------------+-------------------------
//   sample   | in        | sample_valid / sample_ready   | sta_in_t (sample_in, op)
//   result   | out       | result_valid / result_ready   | sta_out_t (result_value, status)
//   cfg      | in        | cfg_we                        | cfg_index, cfg_wdata
//
// One transaction per cycle while result_ready does not stall the pipeline; results leave in order.
// The stages are set by the beta*x multiply, the banked tanh table read, the
// interpolation multiply and the two scaling multiplies, each with its own register.
// Reset clears all stage valid bits and loads alpha and beta with 1.0.
// A stall holds every full stage whose successor cannot move; empty stages still
// fill, so bubbles close up and sample_ready stays high while any slot is free.
module scaled_tanh_activation
    import sta_pkg::*;
#(
    parameter int TANH_TABLE_SIZE = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  sta_in_t              sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output sta_out_t             result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic signed [CFG_W-1:0] alpha_reg;
    logic signed [CFG_W-1:0] beta_reg;

    logic signed [AMAG_W-1:0] a_ext;
    logic signed [31:0]       ab;
    sta_coef_t                coef_next;
    sta_coef_t                coef_reg;

    logic      mid_valid;
    logic      mid_ready;
    sta_tanh_t mid_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            beta_reg  <= BETA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_ALPHA: alpha_reg <= cfg_wdata;
                REG_SLOPE_BETA: beta_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // magnitudes and signs of alpha and alpha*beta, refreshed every cycle
    always_comb
    begin
        a_ext           = {alpha_reg[CFG_W-1], alpha_reg};
        ab              = 32'(alpha_reg) * 32'(beta_reg);
        coef_next.amag  = a_ext[AMAG_W-1] ? AMAG_W'(-a_ext) : AMAG_W'(a_ext);
        coef_next.aneg  = alpha_reg[CFG_W-1];
        coef_next.abmag = ab[31] ? ABMAG_W'(-ab) : ABMAG_W'(ab);
        coef_next.abneg = ab[31];
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    sta_tanh_eval #(
        .TABLE_SIZE (TANH_TABLE_SIZE)
    ) u_eval (
        .clk      (clk),
        .rst_n    (rst_n),
        .beta     (beta_reg),
        .up_valid (sample_valid),
        .up_ready (sample_ready),
        .up_data  (sample),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_data  (mid_data)
    );

    sta_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef_reg),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_data  (mid_data),
        .dn_valid (result_valid),
        .dn_ready (result_ready),
        .dn_data  (result)
    );

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.result_value == '0)
        else $error("unsupported order with nonzero result");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled with empty output stage");

    a_coef_track: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> coef_reg.aneg == $past(alpha_reg[CFG_W-1]))
        else $error("coefficient sign does not follow alpha");

endmodule
